@@ sv/wgm_pkg.sv @@
// Package for the whitelist glob matcher: character codes, parse modes,
// cell commands and the interfaces between parser, cells and top level.
// No dependencies.
package wgm_pkg;

  // Longest name kept, and the width of a name position (0..NAME_MAX)
  localparam int NAME_MAX = 255;
  localparam int LEN_W    = $clog2(NAME_MAX + 1);

  // Characters with a meaning in the whitelist text
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Whitelist parse mode
  typedef enum logic [1:0] {
    MODE_LINE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_PATTERN = 2'd2,
    MODE_SKIP    = 2'd3
  } mode_e;

  // Reach update applied by every cell
  typedef enum logic [1:0] {
    ROP_HOLD = 2'd0,
    ROP_STAR = 2'd1,
    ROP_STEP = 2'd2
  } rop_e;

  // Broadcast from the parser to all cells
  typedef struct packed {
    logic             begin_pat;
    rop_e             op;
    logic             qmark;
    logic [7:0]       chr;
    logic             save;
    logic             wr;
    logic [LEN_W-1:0] wr_idx;
    logic [LEN_W-1:0] len;
  } cell_cmd_t;

  // End-of-stream result waiting for the final saved-reach lookup
  typedef struct packed {
    logic pend;
    logic found;
    logic endp;
    logic ovf;
  } fin_t;

  // Fold A-Z to lower case
  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UP_A && b <= CH_UP_Z) r = b + CASE_OFS;
    return r;
  endfunction

endpackage

@@ sv/whitelist_glob_matcher_core.sv @@
// Top level of the whitelist glob matcher: parser, row of matcher cells and
// a two-entry result queue. Depends on wgm_pkg, wgm_parser and wgm_cell.
//
// Usage: load a name with func_i = 0, one byte per transaction, last_i on
// its final byte; then stream whitelist text with func_i = 1, last_i on the
// final byte. Both channels are valid/stall; a transaction completes when
// valid is high and stall is low. Names longer than NAME_MAX bytes are cut
// and flagged in name_overflow_o.
// Throughput: one input transaction per cycle while in_stall_o is low. Each
// byte updates every cell of the row at once; '*' ripples through the row
// in the same cycle. The result for the final text byte is held in the
// parser's end-of-stream register while the cells do the saved-reach lookup
// at the name length; the result queue then registers it and drives
// out_valid_o until it is taken.
// Stall: the queue holds two results; in_stall_o rises only when a further
// result could not be stored, so text keeps flowing while a result waits.
// Reset: clears the parse state, name length, flags and queue; the name
// bytes themselves are left undefined and are rewritten by the next load.
module whitelist_glob_matcher_core import wgm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       name_overflow_o
);

  cell_cmd_t        cmd;
  fin_t             fin;
  logic             acc;
  logic             hit_any;
  logic [NAME_MAX+1:0] star_c;
  logic [NAME_MAX+1:0] step_c;
  logic [NAME_MAX:0]   hit;

  logic [1:0] q_data0_q, q_data0_d, q_data1_q, q_data1_d, new_ent;
  logic [1:0] cnt_q, cnt_d, occ;
  logic       pop;

  assign acc     = in_valid_i & ~in_stall_o;
  assign hit_any = |hit;

  wgm_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .hit_any_i   (hit_any),
    .cmd_o       (cmd),
    .fin_o       (fin)
  );

  // Row of cells, position 0 on the left
  assign star_c[0] = 1'b0;
  assign step_c[0] = 1'b0;

  for (genvar k = 0; k <= NAME_MAX; k++) begin : g_cell
    wgm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (LEN_W'(k)),
      .cmd_i  (cmd),
      .star_i (star_c[k]),
      .step_i (step_c[k]),
      .star_o (star_c[k+1]),
      .step_o (step_c[k+1]),
      .hit_o  (hit[k])
    );
  end

  // Result queue: entry 0 drives the outputs
  assign pop        = (cnt_q != 2'd0) & ~out_stall_i;
  assign occ        = cnt_q + {1'b0, fin.pend};
  assign in_stall_o = (occ == 2'd3) || ((occ == 2'd2) && !pop);
  assign new_ent    = {fin.found | (fin.endp & hit_any), fin.ovf};

  always_comb begin
    q_data0_d = q_data0_q;
    q_data1_d = q_data1_q;
    cnt_d     = cnt_q - {1'b0, pop};
    if (pop) q_data0_d = q_data1_q;
    if (fin.pend) begin
      if (cnt_d == 2'd0) q_data0_d = new_ent;
      else               q_data1_d = new_ent;
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_data0_q <= q_data0_d;
    q_data1_q <= q_data1_d;
  end

  assign out_valid_o     = (cnt_q != 2'd0);
  assign matched_o       = q_data0_q[1];
  assign name_overflow_o = q_data0_q[0];

endmodule

@@ sv/wgm_cell.sv @@
// One matcher cell: a name byte, a reach bit and a saved-reach bit.
// Depends on wgm_pkg.
module wgm_cell import wgm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] idx_i,
  input  cell_cmd_t        cmd_i,
  input  logic             star_i,
  input  logic             step_i,
  output logic             star_o,
  output logic             step_o,
  output logic             hit_o
);

  logic [7:0] byte_q;
  logic       reach_q, reach_d;
  logic       saved_q, saved_d;
  logic       cur;
  logic       en;

  // Reach seen by this byte: a new pattern starts at position zero
  assign cur = cmd_i.begin_pat ? (idx_i == '0) : reach_q;
  assign en  = (idx_i <= cmd_i.len);

  // Handed to the right-hand neighbor
  assign star_o = star_i | cur;
  assign step_o = cur & (cmd_i.qmark | (byte_q == cmd_i.chr));
  assign hit_o  = saved_q & (idx_i == cmd_i.len);

  always_comb begin
    reach_d = cur;
    case (cmd_i.op)
      ROP_STAR: if (en) reach_d = star_o;
      ROP_STEP: if (en) reach_d = step_i;
      default:  reach_d = cur;
    endcase
    saved_d = cmd_i.save ? reach_d : saved_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= 1'b0;
      saved_q <= 1'b0;
    end else begin
      reach_q <= reach_d;
      saved_q <= saved_d;
    end
  end

  // Name byte, written once per name load
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && cmd_i.wr_idx == idx_i) byte_q <= cmd_i.chr;
  end

endmodule

@@ sv/wgm_parser.sv @@
// Whitelist line parser and name-load control: drives the cell commands and
// holds the match, overflow and end-of-stream state. Depends on wgm_pkg.
module wgm_parser import wgm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      acc_i,
  input  logic      func_i,
  input  logic [7:0] data_byte_i,
  input  logic      last_i,
  input  logic      hit_any_i,
  output cell_cmd_t cmd_o,
  output fin_t      fin_o
);

  mode_e            mode_q, mode_d, mode_after;
  logic             seen_q, seen_d;
  logic             found_q, found_d;
  logic             endp_q, endp_d;
  logic             done_q, done_d;
  logic             ovf_q, ovf_d;
  logic [LEN_W-1:0] len_q, len_d;
  fin_t             fin_q, fin_d;

  logic [7:0]       c;
  logic             is_name, is_text, restart_n, last_text;
  logic             lf, cr, bar, hash, blank, is_term, is_star, is_qm;
  logic             begin_p, in_pat, end_now, adv, save;
  logic             seen_eff, seen_after, found_eff;
  logic [LEN_W-1:0] len_base;
  logic             ovf_base, room;

  // Byte decode
  assign c         = fold(data_byte_i);
  assign is_name   = acc_i & ~func_i;
  assign is_text   = acc_i & func_i;
  assign restart_n = is_name & done_q;
  assign last_text = is_text & last_i;
  assign lf        = (c == CH_LF);
  assign cr        = (c == CH_CR);
  assign bar       = (c == CH_BAR);
  assign hash      = (c == CH_HASH);
  assign blank     = (c == CH_SPACE) || (c == CH_TAB);
  assign is_star   = (c == CH_STAR);
  assign is_qm     = (c == CH_QMARK);
  assign is_term   = lf | cr | bar;

  // Pattern tracking
  assign begin_p    = is_text & (mode_q == MODE_LINE) & ~hash & ~lf & ~cr;
  assign in_pat     = is_text & ((mode_q == MODE_PATTERN) | begin_p);
  assign end_now    = in_pat & is_term;
  assign adv        = in_pat & ~is_term;
  assign save       = adv & ~blank;
  assign seen_eff   = begin_p ? 1'b0 : seen_q;
  assign seen_after = save ? 1'b1 : seen_eff;
  // a pattern ended last cycle looks up its saved reach now
  assign found_eff  = found_q | (endp_q & ~fin_q.pend & hit_any_i);

  // Name load
  assign len_base = done_q ? '0 : len_q;
  assign ovf_base = done_q ? 1'b0 : ovf_q;
  assign room     = (len_base < LEN_W'(NAME_MAX));

  // Mode after one text byte
  always_comb begin
    mode_after = mode_q;
    case (mode_q)
      MODE_COMMENT, MODE_SKIP: begin
        if (lf) mode_after = MODE_LINE;
      end
      MODE_LINE: begin
        if (hash)            mode_after = MODE_COMMENT;
        else if (lf || cr)   mode_after = MODE_LINE;
        else if (bar)        mode_after = MODE_SKIP;
        else                 mode_after = MODE_PATTERN;
      end
      MODE_PATTERN: begin
        if (lf)              mode_after = MODE_LINE;
        else if (cr || bar)  mode_after = MODE_SKIP;
      end
      default: mode_after = MODE_LINE;
    endcase
  end

  // Next state
  always_comb begin
    mode_d  = mode_q;
    seen_d  = seen_q;
    found_d = found_eff;
    endp_d  = 1'b0;
    len_d   = len_q;
    ovf_d   = ovf_q;
    done_d  = done_q;
    fin_d   = fin_q;
    fin_d.pend = last_text;
    if (is_text) begin
      mode_d = mode_after;
      seen_d = end_now ? 1'b0 : seen_after;
      endp_d = (end_now & seen_eff) |
               (last_i & (mode_after == MODE_PATTERN) & seen_after);
      if (last_i) begin
        mode_d      = MODE_LINE;
        seen_d      = 1'b0;
        found_d     = 1'b0;
        fin_d.found = found_eff;
        fin_d.endp  = endp_d;
        fin_d.ovf   = ovf_q;
      end
    end else if (is_name) begin
      len_d  = room ? len_base + 1'b1 : len_base;
      ovf_d  = ovf_base | ~room;
      done_d = last_i;
      if (restart_n) begin
        mode_d  = MODE_LINE;
        seen_d  = 1'b0;
        found_d = 1'b0;
      end
    end
  end

  // Cell commands
  always_comb begin
    cmd_o.begin_pat = begin_p;
    cmd_o.op        = adv ? (is_star ? ROP_STAR : ROP_STEP) : ROP_HOLD;
    cmd_o.qmark     = is_qm;
    cmd_o.chr       = c;
    cmd_o.save      = save;
    cmd_o.wr        = is_name & room;
    cmd_o.wr_idx    = len_base;
    cmd_o.len       = len_q;
    fin_o           = fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINE;
      seen_q  <= 1'b0;
      found_q <= 1'b0;
      endp_q  <= 1'b0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b1;
      fin_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      seen_q  <= seen_d;
      found_q <= found_d;
      endp_q  <= endp_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
      fin_q   <= fin_d;
    end
  end

endmodule

@@ sv/wgm_checker.sv @@
// Port-level checks for the whitelist glob matcher, bound to the top level.
// Depends on whitelist_glob_matcher_core ports only.
module wgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       func_i,
  input logic [7:0] data_byte_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       matched_o,
  input logic       name_overflow_o
);

  logic text_end;
  assign text_end = in_valid_i & ~in_stall_o & func_i & last_i;

  // A held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(matched_o) && $stable(name_overflow_o))
    else $error("result changed while stalled");

  // An accepted end of stream is followed by a result on out_valid_o
  a_result_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_end |-> ##2 out_valid_o)
    else $error("missing result after end of stream");

  // Results only come from an end of stream
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(text_end, 2))
    else $error("result without end of stream");

  // An empty queue never holds up the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result queue");

endmodule

bind whitelist_glob_matcher_core wgm_checker u_wgm_checker (.*);

@@ test/tb_whitelist_glob_matcher_core.sv @@
// Testbench for whitelist_glob_matcher_core: loads names, streams whitelist text and checks
// every match/overflow result against a built-in glob predictor. Depends on wgm_pkg and the core.
module tb_whitelist_glob_matcher_core import wgm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_NAME          = 1'b0;
  localparam logic FUNC_TEXT          = 1'b1;
  localparam int   IDLE_PCT           = 36;
  localparam int   RANDOM_ITEMS       = 60;
  localparam int   MIN_RANDOM_STREAMS = 6;
  localparam int   CYCLE_LIMIT        = 200000;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // DUT connections, all inputs known from time zero
  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       func_i      = FUNC_NAME;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_i      = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       matched_o;
  logic       name_overflow_o;

  // Glob predictor state
  bit [7:0]          name_buf [NAME_MAX];
  int                name_len    = 0;
  bit                name_closed = 1'b1;
  bit                ovf_seen    = 1'b0;
  bit [NAME_MAX:0]   reach       = '0;
  bit [NAME_MAX:0]   reach_snap  = '0;
  mode_e             pmode       = MODE_LINE;
  bit                nonblank    = 1'b0;
  bit                hit         = 1'b0;
  verdict_t          verdict_q [$];
  verdict_t          head_v;

  // Stimulus bookkeeping
  logic [7:0] name_bytes [$];
  logic [7:0] text_bytes [$];
  logic [7:0] cur_name [$];
  bit         name_open    = 1'b0;
  string      name_chars   = "abcAB*? ";
  int         send_gap_pct = IDLE_PCT;
  int         stall_pct    = IDLE_PCT;
  int         item_count   = 0;
  int         stream_count = 0;
  int         fail_count   = 0;
  int         cycle_count  = 0;

  whitelist_glob_matcher_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .matched_o       (matched_o),
    .name_overflow_o (name_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run-time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each result transaction with the oldest expected verdict
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: matched %0b, name_overflow %0b", matched_o, name_overflow_o);
        fail_count++;
      end else begin
        head_v = verdict_q.pop_front();
        if (matched_o !== head_v.matched) begin
          $error("matched: expected %0b, actual %0b", head_v.matched, matched_o);
          fail_count++;
        end
        if (name_overflow_o !== head_v.overflow) begin
          $error("name_overflow: expected %0b, actual %0b", head_v.overflow, name_overflow_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] lc_byte(input logic [7:0] b);
    if (b >= CH_UP_A && b <= CH_UP_Z) return b + CASE_OFS;
    return b;
  endfunction

  function automatic void restart_scan();
    pmode    = MODE_LINE;
    nonblank = 1'b0;
    hit      = 1'b0;
  endfunction

  function automatic void close_pattern();
    if (nonblank && reach_snap[name_len]) hit = 1'b1;
    nonblank = 1'b0;
  endfunction

  // Move the set of reachable name positions over one pattern character
  function automatic void step_reach(input logic [7:0] c);
    bit run;
    run = 1'b0;
    if (c == CH_STAR) begin
      for (int i = 0; i <= name_len; i++) begin
        if (reach[i]) run = 1'b1;
        reach[i] = run;
      end
    end else begin
      for (int i = name_len; i > 0; i--)
        reach[i] = reach[i-1] && (c == CH_QMARK || name_buf[i-1] == c);
      reach[0] = 1'b0;
    end
  endfunction

  // Line parser for one whitelist character
  function automatic void scan_text(input logic [7:0] c);
    case (pmode)
      MODE_COMMENT, MODE_SKIP: begin
        if (c == CH_LF) pmode = MODE_LINE;
        return;
      end
      MODE_LINE: begin
        if (c == CH_HASH) begin
          pmode = MODE_COMMENT;
          return;
        end
        if (c == CH_CR || c == CH_LF) return;
        pmode    = MODE_PATTERN;
        reach    = '0;
        reach[0] = 1'b1;
        nonblank = 1'b0;
      end
      default: ;
    endcase
    if (c == CH_LF || c == CH_CR || c == CH_BAR) begin
      close_pattern();
      pmode = (c == CH_LF) ? MODE_LINE : MODE_SKIP;
      return;
    end
    step_reach(c);
    if (c != CH_SPACE && c != CH_TAB) begin
      reach_snap = reach;
      nonblank   = 1'b1;
    end
  endfunction

  // Update state for one accepted transaction, queue the verdict it causes
  function automatic void glob_predict(input logic f, input logic [7:0] b, input logic l);
    logic [7:0] c;
    verdict_t   v;
    c = lc_byte(b);
    if (f == FUNC_NAME) begin
      if (name_closed) begin
        name_len    = 0;
        ovf_seen    = 1'b0;
        name_closed = 1'b0;
        restart_scan();
      end
      if (name_len < NAME_MAX) begin
        name_buf[name_len] = c;
        name_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (l) name_closed = 1'b1;
    end else begin
      scan_text(c);
      if (l) begin
        if (pmode == MODE_PATTERN) close_pattern();
        v.matched  = hit;
        v.overflow = ovf_seen;
        verdict_q.push_back(v);
        restart_scan();
      end
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic f, input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    data_byte_i <= b;
    last_i      <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    glob_predict(f, b, l);
    item_count++;
  endtask

  task automatic send_name(input bit close);
    for (int i = 0; i < name_bytes.size(); i++)
      send_byte(FUNC_NAME, name_bytes[i], close && i == name_bytes.size() - 1);
    name_bytes.delete();
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++)
      send_byte(FUNC_TEXT, text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
    stream_count++;
  endtask

  // Sender holds off until every outstanding verdict has arrived
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus builders

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  function automatic void put_junk(input int n, input bit allow_lf);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (!allow_lf && b == CH_LF) b = "x";
      text_bytes.push_back(b);
    end
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(0, 1))
      return b ^ CASE_OFS;
    return b;
  endfunction

  function automatic logic [7:0] pick_name_char();
    if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
    return name_chars[$urandom_range(0, name_chars.len() - 1)];
  endfunction

  // Pattern derived from the stored name, with wildcards and mutations
  function automatic void put_glob();
    int stored;
    int start;
    int i;
    int r;
    stored = (cur_name.size() < NAME_MAX) ? cur_name.size() : NAME_MAX;
    start  = (stored > 6) ? stored - $urandom_range(2, 6) : 0;
    if (start > 0 || $urandom_range(0, 99) < 15) text_bytes.push_back(CH_STAR);
    i = start;
    while (i < stored) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        text_bytes.push_back(flip_case(cur_name[i]));
        i++;
      end else if (r < 72) begin
        text_bytes.push_back(CH_QMARK);
        i++;
      end else if (r < 84) begin
        text_bytes.push_back(CH_STAR);
        i += $urandom_range(0, 2);
      end else if (r < 90) begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
        i++;
      end else if (r < 95) begin
        i++;
      end else begin
        text_bytes.push_back(pick_name_char());
      end
    end
    if ($urandom_range(0, 99) < 15) text_bytes.push_back(CH_STAR);
  endfunction

  function automatic void put_blanks(input int n);
    for (int i = 0; i < n; i++) text_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // One whitelist line: body, then LF, CRLF, bar or CR with trailing junk, or nothing at the end
  function automatic void put_line(input bit final_line);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      text_bytes.push_back(CH_HASH);
      put_junk($urandom_range(0, 5), 1'b0);
    end else if (r < 18) begin
      // empty line
    end else if (r < 26) begin
      put_junk($urandom_range(1, 6), 1'b1);
    end else if (r < 32) begin
      put_blanks($urandom_range(1, 3));
    end else begin
      put_glob();
      put_blanks($urandom_range(0, 2));
    end
    case ($urandom_range(0, final_line ? 4 : 3))
      0: text_bytes.push_back(CH_LF);
      1: begin
        text_bytes.push_back(CH_CR);
        text_bytes.push_back(CH_LF);
      end
      2: begin
        text_bytes.push_back(CH_BAR);
        put_junk($urandom_range(0, 4), 1'b0);
        text_bytes.push_back(CH_LF);
      end
      3: begin
        text_bytes.push_back(CH_CR);
        put_junk($urandom_range(0, 3), 1'b0);
        text_bytes.push_back(CH_LF);
      end
      default: ;
    endcase
  endfunction

  // Short name; sometimes left open so whitelist text arrives before it is done
  task automatic load_random_name();
    int         n;
    bit         keep_open;
    logic [7:0] b;
    n         = $urandom_range(1, 8);
    keep_open = ($urandom_range(0, 9) == 0);
    if (!name_open) cur_name.delete();
    for (int i = 0; i < n; i++) begin
      b = pick_name_char();
      name_bytes.push_back(b);
      cur_name.push_back(b);
    end
    send_name(!keep_open);
    name_open = keep_open;
  endtask

  // Letters only; an open name is extended rather than replaced
  task automatic load_long_name(input int n, input bit close);
    logic [7:0] b;
    if (!name_open) cur_name.delete();
    for (int i = 0; i < n; i++) begin
      b = flip_case(8'("a" + $urandom_range(0, 25)));
      name_bytes.push_back(b);
      cur_name.push_back(b);
    end
    send_name(close);
    name_open = !close;
  endtask

  task automatic random_episode();
    int lines;
    if (name_open || cur_name.size() == 0 || $urandom_range(0, 99) < 35) load_random_name();
    lines = $urandom_range(1, 4);
    for (int l = 0; l < lines; l++) put_line(l == lines - 1);
    if (text_bytes.size() == 0) text_bytes.push_back(CH_STAR);
    send_text();
  endtask

  // ---------------------------------------------------------------- tests

  // Field extremes, comments, empty and blank lines, bar and CR, early whitelist, zero bytes
  task automatic test_directed();
    text_bytes.push_back(CH_STAR);
    send_text();
    put_text("aB");
    foreach (text_bytes[i]) name_bytes.push_back(text_bytes[i]);
    text_bytes.delete();
    send_name(1'b1);
    put_text("#\n\n \t|x\r\n?b\t");
    send_text();
    name_bytes.push_back(8'h00);
    send_name(1'b0);
    text_bytes.push_back(8'hFF);
    send_text();
    name_bytes.push_back(8'hFF);
    send_name(1'b1);
    text_bytes.push_back(CH_STAR);
    send_text();
    text_bytes.push_back(8'h00);
    text_bytes.push_back(CH_LF);
    text_bytes.push_back(CH_STAR);
    text_bytes.push_back(8'hFF);
    send_text();
  endtask

  // Name that just fits, left open; then a few more bytes overflow the store
  task automatic test_long_names();
    load_long_name(NAME_MAX, 1'b0);
    text_bytes.push_back(CH_STAR);
    text_bytes.push_back(cur_name[NAME_MAX-2]);
    text_bytes.push_back(cur_name[NAME_MAX-1]);
    text_bytes.push_back(CH_LF);
    text_bytes.push_back(CH_STAR);
    text_bytes.push_back(CH_QMARK);
    send_text();
    load_long_name($urandom_range(1, 4), 1'b1);
    put_glob();
    send_text();
    text_bytes.push_back(CH_STAR);
    send_text();
  endtask

  task automatic test_random_mix();
    int first_item;
    int first_stream;
    first_item   = item_count;
    first_stream = stream_count;
    while (item_count - first_item < RANDOM_ITEMS ||
           stream_count - first_stream < MIN_RANDOM_STREAMS)
      random_episode();
  endtask

  // No idling on either side; many one-byte streams put frequent results into the result queue
  task automatic test_back_to_back();
    int first_item;
    first_item   = item_count;
    send_gap_pct = 0;
    stall_pct    = 0;
    while (item_count - first_item < 50) begin
      if ($urandom_range(0, 2) == 0) begin
        text_bytes.push_back($urandom_range(0, 1) ? CH_STAR : 8'($urandom_range(0, 255)));
        send_text();
      end else begin
        random_episode();
      end
    end
    send_gap_pct = IDLE_PCT;
    stall_pct    = IDLE_PCT;
  endtask

  // Heavy receiver stall against a fast sender so the input side must stall
  task automatic test_result_backlog();
    send_gap_pct = 0;
    stall_pct    = 85;
    for (int i = 0; i < 16; i++) begin
      text_bytes.push_back($urandom_range(0, 1) ? CH_STAR : CH_QMARK);
      send_text();
    end
    send_gap_pct = IDLE_PCT;
    stall_pct    = IDLE_PCT;
  endtask

  task automatic test_pause_for_results();
    for (int i = 0; i < 3; i++) begin
      random_episode();
      wait_all_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_names();
    test_random_mix();
    test_back_to_back();
    test_result_backlog();
    test_pause_for_results();
    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
